// ===== sv/nlp_pkg.sv =====
// ----------------------------------------------------------------------------
// nlp_pkg
// Shared types and constants for the numeric literal parser: stream widths,
// base codes, digit limits, character class record, counter and queue sizing.
// ----------------------------------------------------------------------------
package nlp_pkg;

  // widths of the stream payloads
  localparam int CHAR_W      = 8;
  localparam int VALUE_W     = 64;
  localparam int OUT_COUNT_W = 8;
  localparam int OUT_DATA_W  = VALUE_W + OUT_COUNT_W;

  // internal consumed-character counter, saturating at its all-ones value
  localparam int COUNT_WIDTH = 8;

  // classification queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // base codes, shared by the base_select register and the active base
  localparam logic [1:0] BASE_AUTO = 2'd0;
  localparam logic [1:0] BASE_OCT  = 2'd1;
  localparam logic [1:0] BASE_DEC  = 2'd2;
  localparam logic [1:0] BASE_HEX  = 2'd3;

  // largest decimal and octal digits
  localparam logic [3:0] MAX_DEC_DIGIT = 4'd9;
  localparam logic [3:0] MAX_OCT_DIGIT = 4'd7;

  // character class of one request
  typedef struct packed {
    logic       blank;     // space or tab
    logic       plus;
    logic       minus;
    logic       is_x;      // 'x' or 'X'
    logic       dec;       // '0' to '9'
    logic       hex_alpha; // 'A'-'F' or 'a'-'f'
    logic [3:0] dval;      // digit value when dec or hex_alpha
  } char_class_t;

endpackage

// ===== sv/nlp_front.sv =====
// ----------------------------------------------------------------------------
// nlp_front
// Input side: takes character requests and classifies each one into a
// compact record that the parse engine consumes from the queue.
// ----------------------------------------------------------------------------
module nlp_front (
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [nlp_pkg::CHAR_W-1:0] in_tdata,   // [7:0] char_code
  output logic                       push_valid,
  input  logic                       push_ready,
  output nlp_pkg::char_class_t       push_item
);
  import nlp_pkg::*;

  localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_F  = 8'h46;
  localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_F  = 8'h66;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;
  localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;

  logic              is_dec;
  logic              is_upper;
  logic              is_lower;
  logic [CHAR_W-1:0] off;

  // handshake passes straight to the queue
  assign push_valid = in_tvalid;
  assign in_tready  = push_ready;

  // character classes
  assign is_dec   = (in_tdata >= CH_0) && (in_tdata <= CH_0 + CHAR_W'(MAX_DEC_DIGIT));
  assign is_upper = (in_tdata >= CH_UP_A) && (in_tdata <= CH_UP_F);
  assign is_lower = (in_tdata >= CH_LO_A) && (in_tdata <= CH_LO_F);

  // digit value, letters map to ten and up
  always_comb begin
    if (is_upper) begin
      off = in_tdata - CH_UP_A + 8'd10;
    end else if (is_lower) begin
      off = in_tdata - CH_LO_A + 8'd10;
    end else begin
      off = in_tdata - CH_0;
    end
  end

  always_comb begin
    push_item.blank     = (in_tdata == CH_SPACE) || (in_tdata == CH_TAB);
    push_item.plus      = (in_tdata == CH_PLUS);
    push_item.minus     = (in_tdata == CH_MINUS);
    push_item.is_x      = (in_tdata == CH_LO_X) || (in_tdata == CH_UP_X);
    push_item.dec       = is_dec;
    push_item.hex_alpha = is_upper || is_lower;
    push_item.dval      = off[3:0];
  end

endmodule

// ===== sv/nlp_queue.sv =====
// ----------------------------------------------------------------------------
// nlp_queue
// Short register queue of classified characters between the front and the
// parse engine, so either side can stall on its own.
// ----------------------------------------------------------------------------
module nlp_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  nlp_pkg::char_class_t push_item,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output nlp_pkg::char_class_t pop_item
);
  import nlp_pkg::*;

  char_class_t          entries_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r;
  logic [Q_PTR_W-1:0]   rd_ptr_r;
  logic [Q_CNT_W-1:0]   cnt_r;
  logic                 push;
  logic                 pop;

  assign push_ready = (cnt_r != Q_CNT_W'(Q_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_item   = entries_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== sv/nlp_back.sv =====
// ----------------------------------------------------------------------------
// nlp_back
// Parse engine: walks the literal grammar one classified character per
// cycle unless stalled, accumulates digits, registers the finished result.
// ----------------------------------------------------------------------------
module nlp_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           item_valid,
  output logic                           item_ready,
  input  nlp_pkg::char_class_t           item,
  input  logic [1:0]                     base_select,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [nlp_pkg::OUT_DATA_W-1:0] out_tdata
);
  import nlp_pkg::*;

  typedef enum logic [1:0] {
    PH_LEAD,
    PH_POST_SIGN,
    PH_AFTER_ZERO,
    PH_DIGITS
  } phase_t;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  phase_t                 phase_r, phase_nxt;
  logic                   neg_r, neg_nxt;
  logic [1:0]             base_r, base_nxt;
  logic [VALUE_W-1:0]     acc_r, acc_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic                   out_valid_r;
  logic [OUT_DATA_W-1:0]  out_data_r;

  logic                   fire;
  logic                   emit;
  logic                   do_eval;
  logic                   count_it;
  logic [1:0]             eval_base;
  logic                   digit_ok;
  logic                   is_zero;
  logic [VALUE_W-1:0]     scaled;
  logic [VALUE_W-1:0]     result_value;

  assign item_ready = !out_valid_r || out_tready;
  assign fire       = item_valid && item_ready;
  assign is_zero    = item.dec && (item.dval == 4'd0);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // grammar step
  always_comb begin
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    base_nxt  = base_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    emit      = 1'b0;
    do_eval   = 1'b0;
    count_it  = 1'b0;
    eval_base = base_r;
    digit_ok  = 1'b0;
    scaled    = acc_r;

    unique case (phase_r)
      PH_LEAD, PH_POST_SIGN: begin
        if (item.blank) begin
          count_it = 1'b1;
        end else if (phase_r == PH_LEAD && (item.plus || item.minus)) begin
          neg_nxt   = item.minus;
          count_it  = 1'b1;
          phase_nxt = PH_POST_SIGN;
        end else if (base_select != BASE_AUTO) begin
          do_eval   = 1'b1;
          eval_base = base_select;
        end else if (is_zero) begin
          count_it  = 1'b1;
          phase_nxt = PH_AFTER_ZERO;
        end else begin
          do_eval   = 1'b1;
          eval_base = BASE_DEC;
        end
      end
      PH_AFTER_ZERO: begin
        if (item.is_x) begin
          base_nxt  = BASE_HEX;
          count_it  = 1'b1;
          phase_nxt = PH_DIGITS;
        end else begin
          do_eval   = 1'b1;
          eval_base = BASE_OCT;
        end
      end
      PH_DIGITS: begin
        do_eval = 1'b1;
      end
    endcase

    // digit check and scale for the base in effect
    digit_ok = (item.dec && !(eval_base == BASE_OCT && item.dval > MAX_OCT_DIGIT)) ||
               (eval_base == BASE_HEX && item.hex_alpha);
    case (eval_base)
      BASE_OCT: scaled = acc_r << 3;
      BASE_HEX: scaled = acc_r << 4;
      default:  scaled = (acc_r << 3) + (acc_r << 1);
    endcase

    if (do_eval) begin
      if (digit_ok) begin
        acc_nxt   = scaled + VALUE_W'(item.dval);
        count_it  = 1'b1;
        base_nxt  = eval_base;
        phase_nxt = PH_DIGITS;
      end else begin
        emit = 1'b1;
      end
    end

    // saturating character count
    if (count_it && cnt_r != CNT_MAX) begin
      cnt_nxt = cnt_r + 1'b1;
    end

    // terminator starts a fresh parse
    if (emit) begin
      phase_nxt = PH_LEAD;
      neg_nxt   = 1'b0;
      base_nxt  = BASE_DEC;
      acc_nxt   = '0;
      cnt_nxt   = '0;
    end
  end

  assign result_value = neg_r ? (VALUE_W'(0) - acc_r) : acc_r;

  // parse state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_LEAD;
      neg_r       <= 1'b0;
      base_r      <= BASE_DEC;
      acc_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        phase_r <= phase_nxt;
        neg_r   <= neg_nxt;
        base_r  <= base_nxt;
        acc_r   <= acc_nxt;
        cnt_r   <= cnt_nxt;
      end
      if (fire && emit) begin
        out_valid_r <= 1'b1;
        out_data_r  <= {OUT_COUNT_W'(cnt_r), result_value};
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// ===== sv/numeric_literal_parser.sv =====
// ----------------------------------------------------------------------------
// numeric_literal_parser
// Parses integer literals (optional sign, auto or forced base) from a
// character stream and emits each value with its consumed character count.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   one character per request in in_tdata[7:0]
//   out_*  one result per terminating character: out_tdata[63:0] value,
//          out_tdata[71:64] consumed count; the terminator itself is dropped
//   cfg_*  base_select write: 0 auto, 1 octal, 2 decimal, 3 hex; write only
//          while no parse is in progress and the result has been taken
// Throughput: one character per cycle while the output is not stalled, set
//   by the parse step (shift-add accumulate of the 64-bit value).
// Result path: an accepted terminator is written into the queue; the parse
//   step pops it when the engine is not stalled and loads the output
//   register, which drives out_tvalid.
// Reset (rst_n low at a clock edge): parse state cleared, base_select back
//   to auto, queue and output register empty.
// Stall: a result held by out_tready low stops the parse engine; the
//   two-entry queue then fills and in_tready drops.
// ----------------------------------------------------------------------------
module numeric_literal_parser (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [nlp_pkg::CHAR_W-1:0]     in_tdata,    // [7:0] char_code
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [nlp_pkg::OUT_DATA_W-1:0] out_tdata,   // [63:0] value, [71:64] consumed_count
  input  logic                           cfg_wr_en,
  input  logic [1:0]                     cfg_wr_data  // base_select
);
  import nlp_pkg::*;

  logic [1:0]  base_sel_r;
  logic        push_valid;
  logic        push_ready;
  char_class_t push_item;
  logic        pop_valid;
  logic        pop_ready;
  char_class_t pop_item;

  // base select register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_sel_r <= BASE_AUTO;
    end else if (cfg_wr_en) begin
      base_sel_r <= cfg_wr_data;
    end
  end

  nlp_front u_front (
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  nlp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  nlp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_valid  (pop_valid),
    .item_ready  (pop_ready),
    .item        (pop_item),
    .base_select (base_sel_r),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

endmodule

// ===== sv/nlp_chk.sv =====
// ----------------------------------------------------------------------------
// nlp_chk
// Port-level checks for the numeric literal parser, bound to the top level.
// ----------------------------------------------------------------------------
module nlp_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [7:0]  in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata,
  input logic        cfg_wr_en,
  input logic [1:0]  cfg_wr_data
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed while stalled");

  // right after reset nothing is offered and input space is free
  a_reset_clean: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_tvalid && in_tready)
    else $error("outputs not clean after reset");

  // a parse that consumed nothing has no digits, so its value is zero
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[71:64] == 8'd0) |-> (out_tdata[63:0] == 64'd0))
    else $error("nonzero value with no characters consumed");

endmodule

bind numeric_literal_parser nlp_chk u_nlp_chk (.*);

// ===== bench/numeric_literal_parser_tb.sv =====
// ----------------------------------------------------------------------------
// numeric_literal_parser_tb
// Streams text characters into the literal parser and checks every emitted
// value and consumed count against a cycle-free model of the parse, under
// forced and automatic bases and with random stalls on both stream sides.
// ----------------------------------------------------------------------------
module numeric_literal_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import nlp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int ERR_SHOWN   = 10;
  localparam int DRAIN_WAIT  = 4;

  // character codes the parse reacts to
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_F  = 8'h46;
  localparam logic [7:0] CH_UC_X  = 8'h58;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_F  = 8'h66;
  localparam logic [7:0] CH_LC_X  = 8'h78;

  typedef enum logic [1:0] {
    SCAN_LEAD,
    SCAN_SIGNED,
    SCAN_ZERO,
    SCAN_DIGITS
  } scan_phase_t;

  typedef struct packed {
    logic [VALUE_W-1:0]     value;
    logic [OUT_COUNT_W-1:0] count;
  } literal_t;

  logic                  clk;
  logic                  rst_n       = 1'b0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [CHAR_W-1:0]     in_tdata    = '0;
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_wr_en   = 1'b0;
  logic [1:0]            cfg_wr_data = BASE_AUTO;

  // parse state mirrored by the testbench
  logic [1:0]             base_reg;
  scan_phase_t            phase;
  logic                   neg;
  logic [1:0]             radix_sel;
  logic [VALUE_W-1:0]     acc;
  logic [COUNT_WIDTH-1:0] char_count;

  literal_t expected_literals[$];
  int       error_count;
  int       chars_sent;
  int       in_idle_pct;
  int       out_idle_pct;

  numeric_literal_parser dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),    // [7:0] char_code
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),   // [63:0] value, [71:64] consumed_count
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)  // base_select
  );

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // receiver stalls
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= out_idle_pct);
  end

  task automatic note_error(input string msg);
    error_count++;
    if (error_count <= ERR_SHOWN) begin
      $display("%t: %s", $realtime, msg);
    end
  endtask

  // compare each emitted literal with the oldest expectation
  always @(posedge clk) begin
    literal_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_literals.size() == 0) begin
        note_error($sformatf("unexpected result value %h count %0d",
                             out_tdata[VALUE_W-1:0],
                             out_tdata[OUT_DATA_W-1 -: OUT_COUNT_W]));
      end else begin
        want = expected_literals.pop_front();
        if (out_tdata[VALUE_W-1:0] !== want.value ||
            out_tdata[OUT_DATA_W-1 -: OUT_COUNT_W] !== want.count) begin
          note_error($sformatf("mismatch: got value %h count %0d, want value %h count %0d",
                               out_tdata[VALUE_W-1:0],
                               out_tdata[OUT_DATA_W-1 -: OUT_COUNT_W],
                               want.value, want.count));
        end
      end
    end
  end

  // watchdog
  initial begin
    for (int n = 0; n < CYCLE_LIMIT; n++) @(posedge clk);
    $display("numeric_literal_parser_tb NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // parse model
  // ---------------------------------------------------------------------------

  function automatic int digit_of(input logic [7:0] c, input logic [1:0] b);
    if (c >= CH_ZERO && c <= CH_NINE) begin
      if (b == BASE_OCT && c > CH_SEVEN) return -1;
      return int'(c - CH_ZERO);
    end
    if (b == BASE_HEX) begin
      if (c >= CH_UC_A && c <= CH_UC_F) return int'(c - CH_UC_A) + 10;
      if (c >= CH_LC_A && c <= CH_LC_F) return int'(c - CH_LC_A) + 10;
    end
    return -1;
  endfunction

  function automatic void start_literal();
    phase      = SCAN_LEAD;
    neg        = 1'b0;
    radix_sel  = BASE_DEC;
    acc        = '0;
    char_count = '0;
  endfunction

  function automatic void bump_count();
    if (char_count != '1) char_count++;
  endfunction

  // advance the model by one accepted character
  function automatic void scan_char(input logic [7:0] c);
    bit           to_digit;
    int           dv;
    logic [63:0]  radix;
    literal_t     lit;
    to_digit = 1'b1;
    if (phase == SCAN_LEAD || phase == SCAN_SIGNED) begin
      if (c == CH_SPACE || c == CH_TAB) begin
        bump_count();
        to_digit = 1'b0;
      end else if (phase == SCAN_LEAD && (c == CH_PLUS || c == CH_MINUS)) begin
        neg   = (c == CH_MINUS);
        bump_count();
        phase = SCAN_SIGNED;
        to_digit = 1'b0;
      end else if (base_reg != BASE_AUTO) begin
        radix_sel = base_reg;
        phase     = SCAN_DIGITS;
      end else if (c == CH_ZERO) begin
        bump_count();
        phase = SCAN_ZERO;
        to_digit = 1'b0;
      end else begin
        radix_sel = BASE_DEC;
        phase     = SCAN_DIGITS;
      end
    end else if (phase == SCAN_ZERO) begin
      if (c == CH_UC_X || c == CH_LC_X) begin
        radix_sel = BASE_HEX;
        bump_count();
        phase = SCAN_DIGITS;
        to_digit = 1'b0;
      end else begin
        radix_sel = BASE_OCT;
        phase     = SCAN_DIGITS;
      end
    end
    if (to_digit) begin
      dv = digit_of(c, radix_sel);
      if (dv >= 0) begin
        radix = (radix_sel == BASE_OCT) ? 64'd8 : (radix_sel == BASE_HEX) ? 64'd16 : 64'd10;
        acc   = acc * radix + 64'(dv);
        bump_count();
      end else begin
        lit.value = neg ? (64'd0 - acc) : acc;
        lit.count = OUT_COUNT_W'(char_count);
        expected_literals.push_back(lit);
        start_literal();
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic send_char(input logic [7:0] c);
    if ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    do @(posedge clk); while (!in_tready);
    scan_char(c);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // terminate any open literal, then wait for the block to drain
  task automatic drain();
    if (phase != SCAN_LEAD || char_count != '0) send_char(CH_SEMI);
    in_tvalid <= 1'b0;
    while (expected_literals.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_base(input logic [1:0] b);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= b;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    base_reg = b;
  endtask

  function automatic logic [7:0] rand_digit(input logic [1:0] b);
    int d;
    if (b == BASE_OCT) return CH_ZERO + 8'($urandom_range(7));
    if (b == BASE_DEC) return CH_ZERO + 8'($urandom_range(9));
    d = $urandom_range(15);
    if (d < 10) return CH_ZERO + 8'(d);
    return ($urandom_range(1) ? CH_LC_A : CH_UC_A) + 8'(d - 10);
  endfunction

  function automatic logic [7:0] rand_blank();
    return $urandom_range(1) ? CH_SPACE : CH_TAB;
  endfunction

  // one well-formed literal with random content and a random terminator
  task automatic send_literal();
    logic [1:0] digit_base;
    int         n_digits;
    int         pick;
    repeat ($urandom_range(3)) send_char(rand_blank());
    if ($urandom_range(1)) send_char($urandom_range(1) ? CH_PLUS : CH_MINUS);
    repeat ($urandom_range(2)) send_char(rand_blank());
    pick = $urandom_range(99);
    n_digits = (pick < 8) ? 0 : (pick < 88) ? $urandom_range(6, 1) : $urandom_range(24, 14);
    digit_base = base_reg;
    if (base_reg == BASE_AUTO) begin
      case ($urandom_range(2))
        0: begin
          send_char(CH_ZERO);
          send_char($urandom_range(1) ? CH_LC_X : CH_UC_X);
          digit_base = BASE_HEX;
        end
        1: begin
          send_char(CH_ZERO);
          digit_base = BASE_OCT;
        end
        default: begin
          send_char(CH_ONE + 8'($urandom_range(8)));
          digit_base = BASE_DEC;
        end
      endcase
    end
    repeat (n_digits) send_char(rand_digit(digit_base));
    case ($urandom_range(9))
      0:       send_char($urandom_range(1) ? CH_PLUS : CH_MINUS);
      1:       send_char(CH_NUL);
      2:       send_char($urandom_range(1) ? CH_LC_X : CH_UC_X);
      default: send_char(8'($urandom_range(255)));
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // automatic base: prefixes, signs, blanks and early terminators
  task automatic test_auto_prefix();
    send_text(" -\t0x1fG");
    send_text("0x");
    send_char(8'hFF);
    send_text("08");
    send_text("+-");
    send_char(CH_NUL);
    send_char(CH_SEVEN);
    send_char(CH_NUL);
    send_text("0X7g");
  endtask

  // forced bases: no prefix recognized, base-specific digit sets
  task automatic test_forced_bases();
    write_base(BASE_HEX);
    send_text("0x");
    send_text("FfE9 ");
    write_base(BASE_OCT);
    send_text("-0178");
    write_base(BASE_DEC);
    send_text("99a");
    write_base(BASE_AUTO);
  endtask

  // random literals and noise under one stall pattern, with random base writes
  task automatic test_random_stream(input int n_chars, input int in_pct, input int out_pct);
    int stop_at;
    int next_cfg;
    in_idle_pct  = in_pct;
    out_idle_pct = out_pct;
    stop_at  = chars_sent + n_chars;
    next_cfg = chars_sent + $urandom_range(90, 50);
    while (chars_sent < stop_at) begin
      if (chars_sent >= next_cfg) begin
        write_base(2'($urandom_range(3)));
        next_cfg = chars_sent + $urandom_range(90, 50);
      end
      if ($urandom_range(99) < 85) send_literal();
      else repeat ($urandom_range(4, 1)) send_char(8'($urandom_range(255)));
    end
  endtask

  // long literal: count saturates and the value wraps
  task automatic test_count_saturation();
    write_base(BASE_DEC);
    repeat (20) send_char(rand_blank());
    send_char(CH_MINUS);
    repeat (290) send_char(rand_digit(BASE_DEC));
    send_char(CH_SEMI);
    write_base(BASE_AUTO);
    repeat (270) send_char(rand_blank());
    send_char(CH_ZERO);
    send_char(CH_SEMI);
  endtask

  initial begin
    error_count  = 0;
    chars_sent   = 0;
    in_idle_pct  = 10;
    out_idle_pct = 85;
    base_reg     = BASE_AUTO;
    start_literal();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_auto_prefix();
    test_forced_bases();
    test_random_stream(230, 10, 85);
    test_random_stream(230, 85, 10);
    test_random_stream(230, 0, 0);
    test_count_saturation();

    drain();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("numeric_literal_parser_tb OK");
    end else begin
      $display("numeric_literal_parser_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/nlp_pkg.sv
sv/nlp_front.sv
sv/nlp_queue.sv
sv/nlp_back.sv
sv/numeric_literal_parser.sv
sv/nlp_chk.sv
bench/numeric_literal_parser_tb.sv
